FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed: implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/bepn_pkg.sv
`default_nettype none

package bepn_pkg;

    localparam int SENSOR_WIDTH  = 640;
    localparam int SENSOR_HEIGHT = 480;

    localparam int COORD_W = 10;
    localparam int LOW_W   = 11;
    localparam int SIZE_W  = 11;
    localparam int POS_W   = 16;

    // Back-end divider widths
    localparam int P2_W      = COORD_W + 2;   // pick in half pixels
    localparam int D_W       = P2_W + 1;      // signed offset from the origin
    localparam int N_W       = P2_W + POS_W;  // offset times 65535
    localparam int R_W       = P2_W + 1;      // partial remainder
    localparam int DIV_CNT_W = $clog2(POS_W);

    localparam logic [LOW_W-1:0] LOW_X_INIT = LOW_W'(SENSOR_WIDTH);
    localparam logic [LOW_W-1:0] LOW_Y_INIT = LOW_W'(SENSOR_HEIGHT);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Point selection codes; the unused code behaves as maximum
    localparam logic [1:0] PICK_MAX = 2'd0;
    localparam logic [1:0] PICK_MIN = 2'd1;
    localparam logic [1:0] PICK_MID = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_X_PICK      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_PICK      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_X      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_Y      = 3'd7;

    typedef struct packed {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic               frame_end;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [COORD_W-1:0] box_width;
        logic [COORD_W-1:0] box_height;
    } out_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] area_left;
        logic [COORD_W-1:0] area_top;
        logic [SIZE_W-1:0]  area_width;
        logic [SIZE_W-1:0]  area_height;
        logic [1:0]         x_pick;
        logic [1:0]         y_pick;
        logic               flip_x;
        logic               flip_y;
    } cfg_t;

    // Frame extents handed from front to back
    typedef struct packed {
        logic [LOW_W-1:0]   low_x;
        logic [COORD_W-1:0] high_x;
        logic [LOW_W-1:0]   low_y;
        logic [COORD_W-1:0] high_y;
    } extent_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

FILE: rtl/bepn_front.sv
`default_nettype none

module bepn_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire bepn_pkg::in_item_t in_data,
    input  wire logic               q_full,
    output logic                    in_stall,
    output logic                    push,
    output bepn_pkg::extent_t       push_data
);

    logic [bepn_pkg::LOW_W-1:0]   low_x_reg, low_x_next;
    logic [bepn_pkg::COORD_W-1:0] high_x_reg, high_x_next;
    logic [bepn_pkg::LOW_W-1:0]   low_y_reg, low_y_next;
    logic [bepn_pkg::COORD_W-1:0] high_y_reg, high_y_next;
    logic [bepn_pkg::LOW_W-1:0]   px_ext;
    logic [bepn_pkg::LOW_W-1:0]   py_ext;
    logic                         accept;
    logic [bepn_pkg::LOW_W-1:0]   upd_low_x;
    logic [bepn_pkg::COORD_W-1:0] upd_high_x;
    logic [bepn_pkg::LOW_W-1:0]   upd_low_y;
    logic [bepn_pkg::COORD_W-1:0] upd_high_y;

    // hold points off while the queue has no room
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = accept && in_data.frame_end;

    assign px_ext = {1'b0, in_data.point_x};
    assign py_ext = {1'b0, in_data.point_y};

    always_comb
    begin
        upd_low_x  = (px_ext < low_x_reg) ? px_ext : low_x_reg;
        upd_high_x = (in_data.point_x > high_x_reg) ? in_data.point_x : high_x_reg;
        upd_low_y  = (py_ext < low_y_reg) ? py_ext : low_y_reg;
        upd_high_y = (in_data.point_y > high_y_reg) ? in_data.point_y : high_y_reg;

        push_data.low_x  = upd_low_x;
        push_data.high_x = upd_high_x;
        push_data.low_y  = upd_low_y;
        push_data.high_y = upd_high_y;

        low_x_next  = low_x_reg;
        high_x_next = high_x_reg;
        low_y_next  = low_y_reg;
        high_y_next = high_y_reg;
        if (accept)
        begin
            if (in_data.frame_end)
            begin
                // re-arm for the next frame
                low_x_next  = bepn_pkg::LOW_X_INIT;
                high_x_next = '0;
                low_y_next  = bepn_pkg::LOW_Y_INIT;
                high_y_next = '0;
            end
            else
            begin
                low_x_next  = upd_low_x;
                high_x_next = upd_high_x;
                low_y_next  = upd_low_y;
                high_y_next = upd_high_y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_x_reg  <= bepn_pkg::LOW_X_INIT;
            high_x_reg <= '0;
            low_y_reg  <= bepn_pkg::LOW_Y_INIT;
            high_y_reg <= '0;
        end
        else
        begin
            low_x_reg  <= low_x_next;
            high_x_reg <= high_x_next;
            low_y_reg  <= low_y_next;
            high_y_reg <= high_y_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bepn_fifo.sv
`default_nettype none

module bepn_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire bepn_pkg::extent_t wr_data,
    input  wire logic              pop,
    output bepn_pkg::extent_t      rd_data,
    output bepn_pkg::q_status_t    status
);

    bepn_pkg::extent_t             mem_reg [bepn_pkg::QUEUE_DEPTH];
    logic [bepn_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [bepn_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [bepn_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    assign status.full  = (count_reg == bepn_pkg::QCNT_W'(bepn_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == bepn_pkg::QPTR_W'(bepn_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == bepn_pkg::QPTR_W'(bepn_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bepn_back.sv
`default_nettype none

module bepn_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bepn_pkg::cfg_t      cfg,
    input  wire bepn_pkg::extent_t   rd_data,
    input  wire bepn_pkg::q_status_t q_status,
    output logic                     pop,
    output logic                     busy,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output bepn_pkg::out_item_t      out_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } state_t;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_FULL,
        MODE_DIV
    } mode_t;

    state_t                             state_reg, state_next;
    logic [bepn_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    mode_t                              mode_reg [2];
    mode_t                              mode_next [2];
    logic [bepn_pkg::R_W-1:0]           rem_reg [2];
    logic [bepn_pkg::R_W-1:0]           rem_next [2];
    logic [bepn_pkg::POS_W-1:0]         quo_reg [2];
    logic [bepn_pkg::POS_W-1:0]         quo_next [2];
    logic [bepn_pkg::P2_W-1:0]          div_reg [2];
    logic [bepn_pkg::P2_W-1:0]          div_next [2];
    logic [bepn_pkg::COORD_W-1:0]       bw_reg, bw_next;
    logic [bepn_pkg::COORD_W-1:0]       bh_reg, bh_next;
    logic                               out_valid_reg, out_valid_next;
    bepn_pkg::out_item_t                out_data_reg, out_data_next;

    logic [1:0]                         pick [2];
    logic [bepn_pkg::LOW_W-1:0]         lo [2];
    logic [bepn_pkg::COORD_W-1:0]       hi [2];
    logic [bepn_pkg::COORD_W-1:0]       origin [2];
    logic [bepn_pkg::SIZE_W-1:0]        size [2];
    logic                               flip [2];
    logic [bepn_pkg::P2_W-1:0]          p2 [2];
    logic [bepn_pkg::D_W-1:0]           d [2];
    logic [bepn_pkg::P2_W-1:0]          s2 [2];
    logic [bepn_pkg::N_W-1:0]           num [2];
    logic [bepn_pkg::R_W-1:0]           trial [2];
    logic [bepn_pkg::POS_W-1:0]         val [2];
    logic [bepn_pkg::LOW_W-1:0]         hi_ext_x;
    logic [bepn_pkg::LOW_W-1:0]         hi_ext_y;
    logic [bepn_pkg::LOW_W-1:0]         diff_x;
    logic [bepn_pkg::LOW_W-1:0]         diff_y;
    logic                               out_free;

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == ST_IDLE) && !q_status.empty;

    assign pick[0]   = cfg.x_pick;
    assign pick[1]   = cfg.y_pick;
    assign lo[0]     = rd_data.low_x;
    assign lo[1]     = rd_data.low_y;
    assign hi[0]     = rd_data.high_x;
    assign hi[1]     = rd_data.high_y;
    assign origin[0] = cfg.area_left;
    assign origin[1] = cfg.area_top;
    assign size[0]   = cfg.area_width;
    assign size[1]   = cfg.area_height;
    assign flip[0]   = cfg.flip_x;
    assign flip[1]   = cfg.flip_y;

    assign hi_ext_x = {1'b0, rd_data.high_x};
    assign hi_ext_y = {1'b0, rd_data.high_y};
    assign diff_x   = hi_ext_x - rd_data.low_x;
    assign diff_y   = hi_ext_y - rd_data.low_y;

    // Per-axis set-up: pick in half pixels, offset from origin, numerator d*65535
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            case (pick[i])
                bepn_pkg::PICK_MIN: p2[i] = {lo[i], 1'b0};
                bepn_pkg::PICK_MID: p2[i] = {1'b0, lo[i]} + {2'b00, hi[i]};
                default:            p2[i] = {1'b0, hi[i], 1'b0};
            endcase
            d[i]   = {1'b0, p2[i]} - {2'b00, origin[i], 1'b0};
            s2[i]  = {size[i], 1'b0};
            num[i] = {d[i][bepn_pkg::P2_W-1:0], 16'h0000}
                   - {16'h0000, d[i][bepn_pkg::P2_W-1:0]};
            // one restoring step: bring down next numerator bit
            trial[i] = {rem_reg[i][bepn_pkg::R_W-2:0], quo_reg[i][bepn_pkg::POS_W-1]};
            case (mode_reg[i])
                MODE_ZERO: val[i] = '0;
                MODE_FULL: val[i] = '1;
                default:   val[i] = quo_reg[i];
            endcase
            if (flip[i])
                val[i] = ~val[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bw_next        = bw_reg;
        bh_next        = bh_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        for (int i = 0; i < 2; i++)
        begin
            mode_next[i] = mode_reg[i];
            rem_next[i]  = rem_reg[i];
            quo_next[i]  = quo_reg[i];
            div_next[i]  = div_reg[i];
        end

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        if (size[i] == '0 || d[i][bepn_pkg::D_W-1] || d[i] == '0)
                            mode_next[i] = MODE_ZERO;
                        else if (d[i][bepn_pkg::P2_W-1:0] >= s2[i])
                            mode_next[i] = MODE_FULL;
                        else
                            mode_next[i] = MODE_DIV;
                        // numerator/divisor < 2^16, so the top bits start below the divisor
                        rem_next[i] = {1'b0, num[i][bepn_pkg::N_W-1:bepn_pkg::POS_W]};
                        quo_next[i] = num[i][bepn_pkg::POS_W-1:0];
                        div_next[i] = s2[i];
                    end
                    bw_next    = (hi_ext_x >= rd_data.low_x)
                               ? diff_x[bepn_pkg::COORD_W-1:0] : '0;
                    bh_next    = (hi_ext_y >= rd_data.low_y)
                               ? diff_y[bepn_pkg::COORD_W-1:0] : '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    if (trial[i] >= {1'b0, div_reg[i]})
                    begin
                        rem_next[i] = trial[i] - {1'b0, div_reg[i]};
                        quo_next[i] = {quo_reg[i][bepn_pkg::POS_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[i] = trial[i];
                        quo_next[i] = {quo_reg[i][bepn_pkg::POS_W-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.pos_x      = val[0];
                    out_data_next.pos_y      = val[1];
                    out_data_next.box_width  = bw_reg;
                    out_data_next.box_height = bh_reg;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            mode_reg[i] <= mode_next[i];
            rem_reg[i]  <= rem_next[i];
            quo_reg[i]  <= quo_next[i];
            div_reg[i]  <= div_next[i];
        end
        bw_reg       <= bw_next;
        bh_reg       <= bh_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/blob_extent_position_normalizer_unit.sv
// Blob extent position normaliser.
// Input channel (in_valid / in_stall / in_data): one contour vertex per transfer,
// frame_end set on the last vertex of a frame. Vertices are taken one per cycle;
// in_stall rises only while the two-entry frame queue between front and back is full.
// Output channel (out_valid / out_stall / out_data): one result per frame, holding the
// Q0.16 position on each axis and the box width and height.
// A frame goes from the frame_end transfer through the queue, the back-end set-up,
// the 16-step restoring divider (one quotient bit per cycle, both axes side by side)
// and the hold state to out_valid. The back end takes its next frame only once idle;
// later frames' vertices keep streaming at one per cycle while the queue has room.
// A stalled output holds its result; the back end finishes its next frame and waits
// for the output register to free up, and the queue then fills and stalls the input.
// Configuration: cfg_write / cfg_index / cfg_data, to be written while the block is idle;
// the block does not enforce this. Reset (rst_n, asynchronous, active low) restores the
// register defaults, re-arms the extents and empties the queue and output.
`default_nettype none

`include "assert_macros.svh"

module blob_extent_position_normalizer_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire bepn_pkg::in_item_t                  in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output bepn_pkg::out_item_t                      out_data,
    input  wire logic                                cfg_write,
    input  wire logic [bepn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bepn_pkg::CFG_DATA_W-1:0]     cfg_data
);

    bepn_pkg::cfg_t      cfg_reg, cfg_next;
    logic                push;
    bepn_pkg::extent_t   push_data;
    bepn_pkg::extent_t   rd_data;
    bepn_pkg::q_status_t q_status;
    logic                pop;
    logic                back_busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                bepn_pkg::REG_AREA_LEFT:   cfg_next.area_left   = cfg_data[9:0];
                bepn_pkg::REG_AREA_TOP:    cfg_next.area_top    = cfg_data[9:0];
                bepn_pkg::REG_AREA_WIDTH:  cfg_next.area_width  = cfg_data;
                bepn_pkg::REG_AREA_HEIGHT: cfg_next.area_height = cfg_data;
                bepn_pkg::REG_X_PICK:      cfg_next.x_pick      = cfg_data[1:0];
                bepn_pkg::REG_Y_PICK:      cfg_next.y_pick      = cfg_data[1:0];
                bepn_pkg::REG_FLIP_X:      cfg_next.flip_x      = cfg_data[0];
                bepn_pkg::REG_FLIP_Y:      cfg_next.flip_y      = cfg_data[0];
                default:                   cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.area_left   <= '0;
            cfg_reg.area_top    <= '0;
            cfg_reg.area_width  <= 11'd640;
            cfg_reg.area_height <= 11'd480;
            cfg_reg.x_pick      <= bepn_pkg::PICK_MAX;
            cfg_reg.y_pick      <= bepn_pkg::PICK_MAX;
            cfg_reg.flip_x      <= 1'b0;
            cfg_reg.flip_y      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bepn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .q_full    (q_status.full),
        .in_stall  (in_stall),
        .push      (push),
        .push_data (push_data)
    );

    bepn_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_data),
        .pop     (pop),
        .rd_data (rd_data),
        .status  (q_status)
    );

    bepn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .rd_data   (rd_data),
        .q_status  (q_status),
        .pop       (pop),
        .busy      (back_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // a frame_end transfer always lands in the queue
    `ASSERT_NEXT(a_frame_queued, clk, rst_n, in_valid && !in_stall && in_data.frame_end, !q_status.empty)
    // an idle back end picks up a waiting frame at once
    `ASSERT_NEXT(a_back_starts, clk, rst_n, !q_status.empty && !back_busy, back_busy)
    // no pop from the queue while the back end is mid-frame
    `ASSERT_IMPLIES(a_pop_idle, clk, rst_n, pop, !back_busy && !q_status.empty)

endmodule

`default_nettype wire
